FILE: src/fsd_pkg.sv
// Shared types, constants and arithmetic helpers for the Fibonacci sphere direction block.
// Depends on nothing; imported by fibonacci_sphere_direction_top.
package fsd_pkg;

    localparam int INDEX_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;
    localparam int OUT_W          = 16;
    localparam int TAYLOR_TERMS   = 9;

    localparam logic [15:0] SAMPLE_COUNT_RESET = 16'd64;
    localparam logic [63:0] GOLD_Q64       = 64'h61C8_8646_80B5_83EB;
    localparam logic [63:0] QUARTER_PI_Q64 = 64'hC90F_DAA2_2168_C234;
    localparam logic [63:0] ONE_Q62        = 64'h4000_0000_0000_0000;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    // Four 32x32 partial products: lo*lo, lo*hi, hi*lo, hi*hi.
    typedef logic [3:0][63:0] pp_t;

    typedef struct packed {
        logic [63:0] ts;
        logic [63:0] tc;
        logic [63:0] ss;
        logic [63:0] sc;
        logic [63:0] x2;
        pp_t         pps;
        pp_t         ppc;
        quad_t       quad;
        logic        swap;
        logic        cneg;
        logic        sneg;
    } ang_t;

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic [OUT_W-1:0] z;
        logic             err;
    } out_t;

    function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] a_lo;
        logic [63:0] a_hi;
        logic [63:0] b_lo;
        logic [63:0] b_hi;
        pp_t         pp;
        a_lo  = {32'b0, a[31:0]};
        a_hi  = {32'b0, a[63:32]};
        b_lo  = {32'b0, b[31:0]};
        b_hi  = {32'b0, b[63:32]};
        pp[0] = a_lo * b_lo;
        pp[1] = a_lo * b_hi;
        pp[2] = a_hi * b_lo;
        pp[3] = a_hi * b_hi;
        return pp;
    endfunction

    function automatic logic [127:0] mul_sum(input pp_t pp);
        return {64'b0, pp[0]} + {32'b0, pp[1], 32'b0} + {32'b0, pp[2], 32'b0}
            + {pp[3], 64'b0};
    endfunction

    function automatic int unsigned sin_div(input int unsigned n);
        return (2 * n) * (2 * n + 1);
    endfunction

    function automatic int unsigned cos_div(input int unsigned n);
        return (2 * n - 1) * (2 * n);
    endfunction

    // Rounded-up reciprocal 2^(62+l)/c by shift and subtract; used on constants only.
    // With l = clog2(c), (a * m) >> (62+l) equals a / c for every a below 2^62.
    function automatic logic [63:0] recip_magic(input int unsigned c, input int unsigned l);
        logic [71:0] rem;
        logic [71:0] quo;
        int          b;
        rem = '0;
        quo = '0;
        for (b = 71; b >= 0; b--) begin
            rem = {rem[70:0], (b == int'(62 + l))};
            if (rem >= 72'(c)) begin
                rem    = rem - 72'(c);
                quo[b] = 1'b1;
            end
        end
        if (rem != '0) begin
            quo = quo + 72'd1;
        end
        return quo[63:0];
    endfunction

endpackage

FILE: src/fibonacci_sphere_direction_top.sv
// Fibonacci sphere direction generator: pipelined divider, square root and Taylor sin/cos.
// Depends on fsd_pkg for constants, datapath types and multiply helpers.
//
// One sample index enters per cycle and throughput is one direction per cycle, both
// while the output buffer has room; the block takes a new index before the last is done.
// The depth is set by the azimuth chain (golden-angle product, angle scaling and nine
// Taylor terms, each term a 64-bit multiply and a reciprocal multiply spread over four
// stages), or by the radius chain (one quotient bit and one root bit per stage) when
// FRAC_BITS is large. A two-entry output buffer lets the pipeline keep taking items while
// a result waits on the master side. The sample count is captured with each item; write it
// only while the block is empty.
module fibonacci_sphere_direction_top #(
    parameter int INDEX_BITS = fsd_pkg::INDEX_BITS_DEF,
    parameter int FRAC_BITS  = fsd_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] dir_x, [31:16] dir_y, [47:32] dir_z
    output logic [0:0]  m_tuser    // [0] index_error
);
    import fsd_pkg::*;

    localparam int FB = FRAC_BITS;
    localparam int NB = (INDEX_BITS < 16) ? INDEX_BITS : 16;
    localparam int DW = NB + FB + 3;
    localparam int SW = 2 * FB + 2;
    localparam int PW = FB + 34;
    localparam int YW = (FB + 1 > OUT_W) ? FB + 1 : OUT_W;

    localparam int ANG_TAYLOR0 = 9;
    localparam int ANG_LAST    = ANG_TAYLOR0 + 4 * TAYLOR_TERMS;
    localparam int RAD_LAST    = 2 * FB + 5;
    localparam int LC          = (ANG_LAST > RAD_LAST) ? ANG_LAST : RAD_LAST;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [DW-1:0] dvs;
        logic [FB:0]   quo;
        logic          neg;
        logic [SW-1:0] vrem;
        logic [SW-1:0] root;
        logic [FB:0]   r;
    } rad_t;

    typedef struct packed {
        logic [PW-1:0]    px;
        logic [PW-1:0]    pz;
        logic [OUT_W-1:0] y;
        logic             cneg;
        logic             sneg;
        logic             err;
    } fin_t;

    logic [15:0]   sample_count_reg;
    logic          in_vld_reg;
    logic [NB-1:0] in_idx_reg;
    logic [NB-1:0] in_n_reg;

    logic          vld_reg [1:LC+2];
    logic          err_reg [1:LC+1];
    rad_t          rad_reg [1:LC];
    rad_t          rad_next [1:LC];
    ang_t          ang_reg [1:LC];
    ang_t          ang_next [1:LC];
    fin_t          fin_reg;
    fin_t          fin_next;
    out_t          out_reg;
    out_t          out_next;

    out_t          buf_reg [2];
    logic [1:0]    cnt_reg;
    logic          adv;
    logic          push;
    logic          pop;

    logic [NB:0]   two_i1;
    logic [NB:0]   n_ext;
    logic [NB:0]   i_inc;
    logic [NB:0]   y_num;
    logic          yneg;
    logic          in_err;

    // The pipeline moves as a whole whenever the output buffer has room.
    assign adv      = (cnt_reg != 2'd2);
    assign s_tready = adv;
    assign push     = adv && vld_reg[LC+2];
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {buf_reg[0].z, buf_reg[0].y, buf_reg[0].x};
    assign m_tuser  = buf_reg[0].err;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= SAMPLE_COUNT_RESET;
        end else if (cfg_wr_en) begin
            sample_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (adv) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_idx_reg <= s_tdata[NB-1:0];
            in_n_reg   <= sample_count_reg[NB-1:0];
        end
    end

    // Entry: height numerator |2i+1-N|, azimuth multiplier (i+1) mod N, range check.
    always_comb begin
        two_i1 = {in_idx_reg, 1'b1};
        n_ext  = {1'b0, in_n_reg};
        i_inc  = {1'b0, in_idx_reg} + (NB+1)'(1);
        yneg   = (two_i1 < n_ext);
        y_num  = yneg ? (n_ext - two_i1) : (two_i1 - n_ext);
        in_err = !(in_idx_reg < in_n_reg);

        rad_next[1]      = '0;
        rad_next[1].rem  = (DW'(y_num) << (FB + 1)) + DW'(in_n_reg);
        rad_next[1].dvs  = DW'({in_n_reg, 1'b0});
        rad_next[1].neg  = yneg;

        ang_next[1]      = '0;
        ang_next[1].ts   = (i_inc == n_ext) ? 64'd0 : 64'(i_inc[NB-1:0]);
    end

    for (genvar p = 2; p <= LC; p++) begin : g_rad
        if (p <= FB + 2) begin : g_div
            localparam int J = FB + 2 - p;
            always_comb begin
                rad_next[p] = rad_reg[p-1];
                if (rad_reg[p-1].rem >= (rad_reg[p-1].dvs << J)) begin
                    rad_next[p].rem    = rad_reg[p-1].rem - (rad_reg[p-1].dvs << J);
                    rad_next[p].quo[J] = 1'b1;
                end
            end
        end else if (p == FB + 3) begin : g_sq
            always_comb begin
                rad_next[p]      = rad_reg[p-1];
                rad_next[p].vrem = (SW'(1) << (2 * FB))
                    - SW'(rad_reg[p-1].quo) * SW'(rad_reg[p-1].quo);
                rad_next[p].root = '0;
            end
        end else if (p <= 2 * FB + 4) begin : g_sqrt
            localparam int J = 2 * FB + 4 - p;
            localparam logic [SW-1:0] BIT = SW'(1) << (2 * J);
            logic [SW-1:0] trial;
            always_comb begin
                trial       = rad_reg[p-1].root + BIT;
                rad_next[p] = rad_reg[p-1];
                if (rad_reg[p-1].vrem >= trial) begin
                    rad_next[p].vrem = rad_reg[p-1].vrem - trial;
                    rad_next[p].root = (rad_reg[p-1].root >> 1) + BIT;
                end else begin
                    rad_next[p].root = rad_reg[p-1].root >> 1;
                end
            end
        end else if (p == RAD_LAST) begin : g_round
            // Round the root to nearest: add one when the remainder exceeds the root.
            always_comb begin
                rad_next[p]   = rad_reg[p-1];
                rad_next[p].r = rad_reg[p-1].root[FB:0]
                    + {{FB{1'b0}}, (rad_reg[p-1].vrem > rad_reg[p-1].root)};
            end
        end else begin : g_pass
            always_comb begin
                rad_next[p] = rad_reg[p-1];
            end
        end
    end

    for (genvar p = 2; p <= LC; p++) begin : g_ang
        if (p == 2 || p == 5 || p == 7) begin : g_mul
            always_comb begin
                ang_next[p] = ang_reg[p-1];
                if (p == 2) begin
                    ang_next[p].pps = mul_pp(ang_reg[p-1].ts, GOLD_Q64);
                end else if (p == 5) begin
                    ang_next[p].pps = mul_pp(ang_reg[p-1].ts, QUARTER_PI_Q64);
                end else begin
                    ang_next[p].pps = mul_pp(ang_reg[p-1].ts, ang_reg[p-1].ts);
                end
            end
        end else if (p == 3) begin : g_gold
            logic [127:0] wp;
            always_comb begin
                wp             = mul_sum(ang_reg[p-1].pps);
                ang_next[p]    = ang_reg[p-1];
                ang_next[p].ts = wp[63:0];
            end
        end else if (p == 4) begin : g_fold
            // Mirror the upper half of each quadrant so the angle stays within an octant.
            logic [63:0] u;
            logic [63:0] t;
            always_comb begin
                u                = {2'b0, ang_reg[p-1].ts[61:0]};
                t                = ang_reg[p-1].ts[61] ? (ONE_Q62 - u) : u;
                ang_next[p]      = ang_reg[p-1];
                ang_next[p].quad = quad_t'(ang_reg[p-1].ts[63:62]);
                ang_next[p].swap = ang_reg[p-1].ts[61];
                ang_next[p].ts   = t << 1;
            end
        end else if (p == 6) begin : g_theta
            logic [127:0] wp;
            always_comb begin
                wp             = mul_sum(ang_reg[p-1].pps);
                ang_next[p]    = ang_reg[p-1];
                ang_next[p].ts = wp[127:64];
                ang_next[p].ss = wp[127:64];
            end
        end else if (p == 8) begin : g_x2
            logic [127:0] wp;
            always_comb begin
                wp             = mul_sum(ang_reg[p-1].pps);
                ang_next[p]    = ang_reg[p-1];
                ang_next[p].x2 = wp[125:62];
                ang_next[p].tc = ONE_Q62;
                ang_next[p].sc = ONE_Q62;
            end
        end else if (p < ANG_LAST) begin : g_term
            localparam int TERM = (p - ANG_TAYLOR0) / 4 + 1;
            localparam int SUB  = (p - ANG_TAYLOR0) % 4;
            localparam int unsigned DS = sin_div(TERM);
            localparam int unsigned DC = cos_div(TERM);
            localparam int LS = $clog2(DS);
            localparam int LCS = $clog2(DC);
            localparam logic [63:0] MS = recip_magic(DS, LS);
            localparam logic [63:0] MC = recip_magic(DC, LCS);
            logic [127:0] ws;
            logic [127:0] wc;
            always_comb begin
                ang_next[p] = ang_reg[p-1];
                ws          = '0;
                wc          = '0;
                case (SUB)
                    0: begin
                        ang_next[p].pps = mul_pp(ang_reg[p-1].ts, ang_reg[p-1].x2);
                        ang_next[p].ppc = mul_pp(ang_reg[p-1].tc, ang_reg[p-1].x2);
                    end
                    1: begin
                        ws             = mul_sum(ang_reg[p-1].pps);
                        wc             = mul_sum(ang_reg[p-1].ppc);
                        ang_next[p].ts = ws[125:62];
                        ang_next[p].tc = wc[125:62];
                    end
                    2: begin
                        ang_next[p].pps = mul_pp(ang_reg[p-1].ts, MS);
                        ang_next[p].ppc = mul_pp(ang_reg[p-1].tc, MC);
                    end
                    default: begin
                        // The reciprocal product gives the truncated quotient of the term.
                        ws             = mul_sum(ang_reg[p-1].pps) >> (62 + LS);
                        wc             = mul_sum(ang_reg[p-1].ppc) >> (62 + LCS);
                        ang_next[p].ts = ws[63:0];
                        ang_next[p].tc = wc[63:0];
                        if (TERM % 2 == 1) begin
                            ang_next[p].ss = ang_reg[p-1].ss - ws[63:0];
                            ang_next[p].sc = ang_reg[p-1].sc - wc[63:0];
                        end else begin
                            ang_next[p].ss = ang_reg[p-1].ss + ws[63:0];
                            ang_next[p].sc = ang_reg[p-1].sc + wc[63:0];
                        end
                    end
                endcase
            end
        end else if (p == ANG_LAST) begin : g_quad
            logic [63:0] s_v;
            logic [63:0] c_v;
            logic [63:0] cx;
            logic [63:0] sz;
            always_comb begin
                s_v         = ang_reg[p-1].swap ? ang_reg[p-1].sc : ang_reg[p-1].ss;
                c_v         = ang_reg[p-1].swap ? ang_reg[p-1].ss : ang_reg[p-1].sc;
                ang_next[p] = ang_reg[p-1];
                case (ang_reg[p-1].quad)
                    QUAD_0: begin
                        cx = c_v; sz = s_v;
                        ang_next[p].cneg = 1'b0; ang_next[p].sneg = 1'b0;
                    end
                    QUAD_1: begin
                        cx = s_v; sz = c_v;
                        ang_next[p].cneg = 1'b1; ang_next[p].sneg = 1'b0;
                    end
                    QUAD_2: begin
                        cx = c_v; sz = s_v;
                        ang_next[p].cneg = 1'b1; ang_next[p].sneg = 1'b1;
                    end
                    default: begin
                        cx = s_v; sz = c_v;
                        ang_next[p].cneg = 1'b0; ang_next[p].sneg = 1'b1;
                    end
                endcase
                // Round sin and cos from Q62 down to Q32.
                ang_next[p].ts = (cx + (64'd1 << 29)) >> 30;
                ang_next[p].tc = (sz + (64'd1 << 29)) >> 30;
            end
        end else begin : g_pass
            always_comb begin
                ang_next[p] = ang_reg[p-1];
            end
        end
    end

    for (genvar p = 1; p <= LC; p++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (adv) begin
                rad_reg[p] <= rad_next[p];
                ang_reg[p] <= ang_next[p];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 1; s <= LC + 2; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[1] <= in_vld_reg;
            for (int s = 2; s <= LC + 2; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            err_reg[1] <= in_err;
            for (int s = 2; s <= LC + 1; s++) begin
                err_reg[s] <= err_reg[s-1];
            end
        end
    end

    logic [YW-1:0] ymag_ext;
    logic [YW-1:0] yval;

    always_comb begin
        ymag_ext      = YW'(rad_reg[LC].quo);
        yval          = rad_reg[LC].neg ? (YW'(0) - ymag_ext) : ymag_ext;
        fin_next.px   = PW'(rad_reg[LC].r) * PW'(ang_reg[LC].ts[32:0]);
        fin_next.pz   = PW'(rad_reg[LC].r) * PW'(ang_reg[LC].tc[32:0]);
        fin_next.y    = yval[OUT_W-1:0];
        fin_next.cneg = ang_reg[LC].cneg;
        fin_next.sneg = ang_reg[LC].sneg;
        fin_next.err  = err_reg[LC];
    end

    logic [PW-1:0] mag_x;
    logic [PW-1:0] mag_z;
    logic [PW-1:0] sx;
    logic [PW-1:0] sz_v;

    always_comb begin
        mag_x = (fin_reg.px + (PW'(1) << 31)) >> 32;
        mag_z = (fin_reg.pz + (PW'(1) << 31)) >> 32;
        sx    = fin_reg.cneg ? (PW'(0) - mag_x) : mag_x;
        sz_v  = fin_reg.sneg ? (PW'(0) - mag_z) : mag_z;
        out_next.err = err_reg[LC+1];
        if (err_reg[LC+1]) begin
            out_next.x = '0;
            out_next.y = '0;
            out_next.z = '0;
        end else begin
            out_next.x = sx[OUT_W-1:0];
            out_next.y = fin_reg.y;
            out_next.z = sz_v[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fin_reg <= fin_next;
            out_reg <= out_next;
        end
    end

    // Two-entry output buffer; entry 0 drives the master side.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !pop) begin
            if (cnt_reg == 2'd0) begin
                buf_reg[0] <= out_reg;
            end else begin
                buf_reg[1] <= out_reg;
            end
        end else if (pop && !push) begin
            buf_reg[0] <= buf_reg[1];
        end else if (push && pop) begin
            buf_reg[0] <= out_reg;
        end
    end

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("index error result carries nonzero components");

    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 && !m_tready |=> !s_tready)
        else $error("input taken while output buffer full");

    a_push_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && vld_reg[LC+2] |=> m_tvalid)
        else $error("finished item did not reach the master side");

endmodule
